// ===== sv/rle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and constants of the run-length stream decoder.
// ----------------------------------------------------------------------------
package rle_pkg;

   // Header magic word, little-endian on the stream
   localparam logic [31:0] MAGIC_WORD = 32'h2E454C52;

   // Bit positions in the first token byte
   localparam int FL_EXT_BIT  = 7;
   localparam int FL_REPE_BIT = 6;
   localparam int FL_WORD_BIT = 5;
   localparam int FL_ALPH_BIT = 4;

   // Stored token flags: repeat, word, alpha
   localparam int TF_REPE = 2;
   localparam int TF_WORD = 1;
   localparam int TF_ALPH = 0;

   localparam int CNT_W = 27;

   typedef enum logic [2:0] {
      PH_HDR   = 3'd0,
      PH_SKIP  = 3'd1,
      PH_TOK   = 3'd2,
      PH_EXT   = 3'd3,
      PH_LIT   = 3'd4,
      PH_RBYTE = 3'd5,
      PH_RWORD = 3'd6,
      PH_ALPHA = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_BAD_MAGIC = 3'd2,
      ST_TRUNC    = 3'd3,
      ST_MISMATCH = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic             elem_valid;
      logic             elem_is_word;
      logic [31:0]      elem_value;
      logic [CNT_W-1:0] repeat_count;
      logic             stream_done;
      logic [2:0]       end_status;
      logic [31:0]      bytes_out;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== sv/rle_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_req_if
// Input channel: one compressed byte per item.
// ----------------------------------------------------------------------------
interface rle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/rle_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_rsp_if
// Result channel: one decoded element or run, or the end status.
// ----------------------------------------------------------------------------
interface rle_rsp_if;
   logic        valid;
   logic        ready;
   logic        elem_valid;
   logic        elem_is_word;
   logic [31:0] elem_value;
   logic [26:0] repeat_count;
   logic        stream_done;
   logic [2:0]  end_status;
   logic [31:0] bytes_out;

   modport source (output valid, output elem_valid, output elem_is_word,
                   output elem_value, output repeat_count, output stream_done,
                   output end_status, output bytes_out, input ready);
   modport sink   (input valid, input elem_valid, input elem_is_word,
                   input elem_value, input repeat_count, input stream_done,
                   input end_status, input bytes_out, output ready);
endinterface
`default_nettype wire

// ===== sv/rle_req_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_req_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module rle_req_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rle_pkg::req_item_type in_item,
   output logic                       out_valid,
   output rle_pkg::req_item_type      out_item,
   input  wire logic                  out_take
);
   import rle_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         accept;

   // Accept when empty or when the held item leaves this cycle
   assign in_ready = !valid_ff || out_take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

// ===== sv/rle_parse_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_parse_core
// Header check, token parser and payload decode, one byte per cycle while results have room.
// ----------------------------------------------------------------------------
module rle_parse_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire rle_pkg::req_item_type in_item,
   input  wire logic                  out_space,
   output logic                       take,
   output logic                       produce,
   output rle_pkg::rsp_item_type      out_item
);
   import rle_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [2:0]       idx_ff, idx_in;
   logic [31:0]      magic_ff, magic_in;
   logic [31:0]      exp_len_ff, exp_len_in;
   logic [2:0]       flags_ff, flags_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [31:0]      data_ff, data_in;
   logic [7:0]       alpha_ff, alpha_in;
   logic [31:0]      total_ff, total_in;

   logic [7:0]  b;
   logic        ev, isw, start_payload;
   logic [31:0] val, add_amt;
   logic [CNT_W-1:0] cnt;
   status_type  status;

   assign b = in_item.in_byte;

   // Next state for the byte in the input register
   always_comb begin
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      magic_in      = magic_ff;
      exp_len_in    = exp_len_ff;
      flags_in      = flags_ff;
      run_in        = run_ff;
      left_in       = left_ff;
      data_in       = data_ff;
      alpha_in      = alpha_ff;
      ev            = 1'b0;
      isw           = 1'b0;
      val           = '0;
      cnt           = '0;
      add_amt       = '0;
      start_payload = 1'b0;

      case (phase_ff)
         PH_HDR: begin
            if (!idx_ff[2]) begin
               magic_in[{idx_ff[1:0], 3'b000} +: 8] = b;
            end else begin
               exp_len_in[{idx_ff[1:0], 3'b000} +: 8] = b;
            end
            if (idx_ff == 3'd7) begin
               idx_in   = '0;
               phase_in = (magic_ff == MAGIC_WORD) ? PH_TOK : PH_SKIP;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         PH_SKIP: begin
         end
         PH_TOK: begin
            if (b[FL_REPE_BIT]) begin
               flags_in = b[FL_REPE_BIT:FL_ALPH_BIT];
               run_in   = {{(CNT_W-4){1'b0}}, b[3:0]};
            end else begin
               flags_in = '0;
               run_in   = {{(CNT_W-6){1'b0}}, b[5:0]};
            end
            if (b[FL_EXT_BIT]) begin
               idx_in   = 3'd1;
               phase_in = PH_EXT;
            end else begin
               start_payload = 1'b1;
            end
         end
         PH_EXT: begin
            run_in = {run_ff[CNT_W-8:0], b[6:0]};
            idx_in = idx_ff + 3'd1;
            if (!b[FL_EXT_BIT] || idx_ff >= 3'd3) begin
               start_payload = 1'b1;
            end
         end
         PH_LIT: begin
            ev      = 1'b1;
            val     = {24'd0, b};
            cnt     = {{(CNT_W-1){1'b0}}, 1'b1};
            add_amt = 32'd1;
            left_in = left_ff - {{(CNT_W-1){1'b0}}, 1'b1};
            if (left_in == '0) begin
               phase_in = PH_TOK;
            end
         end
         PH_RBYTE: begin
            if (run_ff != '0) begin
               ev      = 1'b1;
               val     = {24'd0, b};
               cnt     = run_ff;
               add_amt = {{(32-CNT_W){1'b0}}, run_ff};
            end
            phase_in = PH_TOK;
         end
         PH_RWORD: begin
            data_in[{idx_ff[1:0], 3'b000} +: 8] = data_ff[{idx_ff[1:0], 3'b000} +: 8] | b;
            if (idx_ff >= 3'd3) begin
               if (run_ff != '0) begin
                  ev      = 1'b1;
                  isw     = 1'b1;
                  val     = data_in;
                  cnt     = run_ff;
                  add_amt = {{(30-CNT_W){1'b0}}, run_ff, 2'b00};
               end
               phase_in = PH_TOK;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         PH_ALPHA: begin
            if (idx_ff >= 3'd4) begin
               // shared alpha byte opens the group
               alpha_in = b;
               idx_in   = '0;
               data_in  = '0;
               if (left_ff == '0) begin
                  phase_in = PH_TOK;
               end
            end else if (idx_ff < 3'd2) begin
               if (idx_ff[0]) begin
                  data_in[23:16] = data_ff[23:16] | b;
               end else begin
                  data_in[31:24] = data_ff[31:24] | b;
               end
               idx_in = idx_ff + 3'd1;
            end else begin
               ev       = 1'b1;
               isw      = 1'b1;
               val      = data_ff | {16'd0, b, alpha_ff};
               cnt      = {{(CNT_W-1){1'b0}}, 1'b1};
               add_amt  = 32'd4;
               data_in  = '0;
               idx_in   = '0;
               left_in  = left_ff - {{(CNT_W-1){1'b0}}, 1'b1};
               if (left_in == '0) begin
                  phase_in = PH_TOK;
               end
            end
         end
         default: begin
         end
      endcase

      // Pick the payload phase from the freshly parsed token
      if (start_payload) begin
         if (!flags_in[TF_REPE]) begin
            left_in  = run_in;
            phase_in = (run_in == '0) ? PH_TOK : PH_LIT;
         end else if (flags_in[TF_WORD]) begin
            data_in  = '0;
            idx_in   = '0;
            phase_in = PH_RWORD;
         end else if (flags_in[TF_ALPH]) begin
            left_in  = run_in;
            idx_in   = 3'd4;
            phase_in = PH_ALPHA;
         end else begin
            phase_in = PH_RBYTE;
         end
      end

      total_in = total_ff + add_amt;

      // End status on the final byte
      if (!in_item.last_byte) begin
         status = ST_OK;
      end else if (phase_ff == PH_HDR) begin
         status = ST_SHORT;
      end else if (phase_in == PH_SKIP) begin
         status = ST_BAD_MAGIC;
      end else if (phase_in != PH_TOK) begin
         status = ST_TRUNC;
      end else if (total_in != exp_len_ff) begin
         status = ST_MISMATCH;
      end else begin
         status = ST_OK;
      end
   end

   // Fire when a result has room, or when no result comes of this byte
   assign produce = ev || in_item.last_byte;
   assign take    = in_valid && (!produce || out_space);

   always_comb begin
      out_item.elem_valid   = ev;
      out_item.elem_is_word = isw;
      out_item.elem_value   = val;
      out_item.repeat_count = cnt;
      out_item.stream_done  = in_item.last_byte;
      out_item.end_status   = status;
      out_item.bytes_out    = total_in;
   end

   // Advance state; the final byte returns the parser to the header phase
   always_ff @(posedge clock) begin
      if (reset || (take && in_item.last_byte)) begin
         phase_ff   <= PH_HDR;
         idx_ff     <= '0;
         magic_ff   <= '0;
         exp_len_ff <= '0;
         flags_ff   <= '0;
         run_ff     <= '0;
         left_ff    <= '0;
         data_ff    <= '0;
         alpha_ff   <= '0;
         total_ff   <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         magic_ff   <= magic_in;
         exp_len_ff <= exp_len_in;
         flags_ff   <= flags_in;
         run_ff     <= run_in;
         left_ff    <= left_in;
         data_ff    <= data_in;
         alpha_ff   <= alpha_in;
         total_ff   <= total_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/rle_rsp_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_rsp_buffer
// Two-entry result queue; its registered room flag decouples the two sides.
// ----------------------------------------------------------------------------
module rle_rsp_buffer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire rle_pkg::rsp_item_type push_item,
   output logic                       space,
   output logic                       out_valid,
   output rle_pkg::rsp_item_type      out_item,
   input  wire logic                  out_ready
);
   import rle_pkg::*;

   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign space     = (count_ff != 2'd2);
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// ===== sv/rle_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_stream_decoder_unit
// Run-length stream decoder: header check, token parse, element/run output.
// ----------------------------------------------------------------------------
//   channel   dir  handshake        payload
//   req_bus   in   valid / ready    in_byte, last_byte
//   rsp_bus   out  valid / ready    elem_*, repeat_count, stream_done,
//                                   end_status, bytes_out
//
// One byte per cycle while the result queue has room; an accepted byte is held
// in the input register, and its result goes from the parse logic into the queue.
// Bytes that yield no result pass through the parser without using the queue.
// Reset is synchronous and clears parser state, the input register and the result queue.
// With rsp_bus.ready low the two-entry result queue fills, and req_bus.ready
// drops once the input register holds a byte that needs a result slot.
// ----------------------------------------------------------------------------
module rle_stream_decoder_unit (
   input  wire logic clock,
   input  wire logic reset,
   rle_req_if.sink   req_bus,
   rle_rsp_if.source rsp_bus
);
   import rle_pkg::*;

   req_item_type req_item;
   req_item_type held_item;
   logic         held_valid;
   logic         take;
   logic         produce;
   logic         space;
   rsp_item_type core_item;
   rsp_item_type buf_item;

   assign req_item.in_byte   = req_bus.in_byte;
   assign req_item.last_byte = req_bus.last_byte;

   rle_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .out_valid (held_valid),
      .out_item  (held_item),
      .out_take  (take)
   );

   rle_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_item   (held_item),
      .out_space (space),
      .take      (take),
      .produce   (produce),
      .out_item  (core_item)
   );

   rle_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (take && produce),
      .push_item (core_item),
      .space     (space),
      .out_valid (rsp_bus.valid),
      .out_item  (buf_item),
      .out_ready (rsp_bus.ready)
   );

   assign rsp_bus.elem_valid   = buf_item.elem_valid;
   assign rsp_bus.elem_is_word = buf_item.elem_is_word;
   assign rsp_bus.elem_value   = buf_item.elem_value;
   assign rsp_bus.repeat_count = buf_item.repeat_count;
   assign rsp_bus.stream_done  = buf_item.stream_done;
   assign rsp_bus.end_status   = buf_item.end_status;
   assign rsp_bus.bytes_out    = buf_item.bytes_out;
endmodule
`default_nettype wire

// ===== sv/rle_stream_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_stream_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rle_stream_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        elem_valid,
   input wire logic        elem_is_word,
   input wire logic [31:0] elem_value,
   input wire logic [26:0] repeat_count,
   input wire logic        stream_done,
   input wire logic [2:0]  end_status,
   input wire logic [31:0] bytes_out
);
   import rle_pkg::*;

   // No result directly after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Hold a stalled result
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(elem_value) && $stable(bytes_out)
         && $stable(repeat_count) && $stable(end_status))
      else $error("result payload changed while stalled");

   // Status only on the final byte's result
   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !stream_done |-> end_status == ST_OK)
      else $error("status reported before the final byte");

   // A result without an element carries zero fields and is a done report
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !elem_valid |-> stream_done && !elem_is_word
         && elem_value == 32'd0 && repeat_count == 27'd0)
      else $error("empty result with element fields set");
endmodule

bind rle_stream_decoder_unit rle_stream_checker u_stream_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .elem_valid   (rsp_bus.elem_valid),
   .elem_is_word (rsp_bus.elem_is_word),
   .elem_value   (rsp_bus.elem_value),
   .repeat_count (rsp_bus.repeat_count),
   .stream_done  (rsp_bus.stream_done),
   .end_status   (rsp_bus.end_status),
   .bytes_out    (rsp_bus.bytes_out)
);
`default_nettype wire

// ===== test/rle_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_stream_decoder_unit_tb
// Feeds compressed byte streams (headers, literal, byte, word and alpha runs,
// short, corrupted and truncated streams, a total that wraps) through the
// decoder under random input gaps and output stalls, and checks every result
// item against a cycle-free software decoder kept in step with the input.
// ----------------------------------------------------------------------------
module rle_stream_decoder_unit_tb;
   import rle_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int STALL_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef enum int {
      TK_LITERAL,
      TK_RBYTE,
      TK_RWORD,
      TK_ALPHA,
      TK_WORD_ALPHA
   } token_kind_type;

   logic clock;
   logic reset;

   rle_req_if req_bus ();
   rle_rsp_if rsp_bus ();

   rle_stream_decoder_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Stimulus and expectation stores
   req_item_type pending_bytes[$];
   rsp_item_type predicted_runs[$];
   logic [7:0]   stream_buf[$];
   logic [31:0]  stream_total;
   int           queued_count = 0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int stall_requests = 0;
   int stall_served   = 0;
   int stall_left     = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   bit req_taken      = 1'b0;

   // Decoder state as the block should hold it
   phase_type   dec_phase = PH_HDR;
   logic [2:0]  dec_index = '0;
   logic [31:0] dec_magic = '0;
   logic [31:0] dec_len   = '0;
   logic [3:0]  dec_flags = '0;
   logic [26:0] dec_run   = '0;
   logic [26:0] dec_left  = '0;
   logic [31:0] dec_word  = '0;
   logic [7:0]  dec_alpha = '0;
   logic [31:0] dec_total = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Decoder prediction
   // ---------------------------------------------------------------------

   // Select the payload phase from the stored token flags
   task automatic start_payload();
      if (!dec_flags[TF_REPE]) begin
         dec_left  = dec_run;
         dec_phase = (dec_run == 0) ? PH_TOK : PH_LIT;
      end else if (dec_flags[TF_WORD]) begin
         dec_word  = '0;
         dec_index = '0;
         dec_phase = PH_RWORD;
      end else if (dec_flags[TF_ALPH]) begin
         dec_left  = dec_run;
         dec_index = 3'd4;
         dec_phase = PH_ALPHA;
      end else begin
         dec_phase = PH_RBYTE;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      rsp_item_type r;
      status_type   status;
      logic         from_header;
      r           = '0;
      status      = ST_OK;
      from_header = (dec_phase == PH_HDR);
      case (dec_phase)
         PH_HDR: begin
            if (dec_index < 3'd4)
               dec_magic = dec_magic | (32'(b) << (8 * dec_index[1:0]));
            else
               dec_len = dec_len | (32'(b) << (8 * dec_index[1:0]));
            if (dec_index == 3'd7) begin
               dec_index = '0;
               dec_phase = (dec_magic == MAGIC_WORD) ? PH_TOK : PH_SKIP;
            end else begin
               dec_index = dec_index + 3'd1;
            end
         end
         PH_SKIP: begin
         end
         PH_TOK: begin
            if (b[FL_REPE_BIT]) begin
               dec_flags = b[7:4];
               dec_run   = 27'(b[3:0]);
            end else begin
               dec_flags = {b[7:6], 2'b00};
               dec_run   = 27'(b[5:0]);
            end
            if (b[FL_EXT_BIT]) begin
               dec_index = 3'd1;
               dec_phase = PH_EXT;
            end else begin
               start_payload();
            end
         end
         PH_EXT: begin
            dec_run   = {dec_run[19:0], b[6:0]};
            dec_index = dec_index + 3'd1;
            if (!b[FL_EXT_BIT] || dec_index >= 3'd4)
               start_payload();
         end
         PH_LIT: begin
            r.elem_valid   = 1'b1;
            r.elem_value   = 32'(b);
            r.repeat_count = 27'd1;
            dec_total      = dec_total + 32'd1;
            dec_left       = dec_left - 27'd1;
            if (dec_left == 0)
               dec_phase = PH_TOK;
         end
         PH_RBYTE: begin
            if (dec_run != 0) begin
               r.elem_valid   = 1'b1;
               r.elem_value   = 32'(b);
               r.repeat_count = dec_run;
               dec_total      = dec_total + 32'(dec_run);
            end
            dec_phase = PH_TOK;
         end
         PH_RWORD: begin
            dec_word = dec_word | (32'(b) << (8 * dec_index[1:0]));
            if (dec_index >= 3'd3) begin
               if (dec_run != 0) begin
                  r.elem_valid   = 1'b1;
                  r.elem_is_word = 1'b1;
                  r.elem_value   = dec_word;
                  r.repeat_count = dec_run;
                  dec_total      = dec_total + (32'(dec_run) << 2);
               end
               dec_phase = PH_TOK;
            end else begin
               dec_index = dec_index + 3'd1;
            end
         end
         default: begin
            // Alpha byte first, then three bytes per word
            if (dec_index >= 3'd4) begin
               dec_alpha = b;
               dec_index = '0;
               dec_word  = '0;
               if (dec_left == 0)
                  dec_phase = PH_TOK;
            end else if (dec_index < 3'd2) begin
               dec_word  = dec_word | (32'(b) << (24 - 8 * dec_index));
               dec_index = dec_index + 3'd1;
            end else begin
               dec_word       = dec_word | {16'h0000, b, dec_alpha};
               r.elem_valid   = 1'b1;
               r.elem_is_word = 1'b1;
               r.elem_value   = dec_word;
               r.repeat_count = 27'd1;
               dec_total      = dec_total + 32'd4;
               dec_word       = '0;
               dec_index      = '0;
               dec_left       = dec_left - 27'd1;
               if (dec_left == 0)
                  dec_phase = PH_TOK;
            end
         end
      endcase

      if (r.elem_valid || last) begin
         if (last) begin
            if (from_header)
               status = ST_SHORT;
            else if (dec_phase == PH_SKIP)
               status = ST_BAD_MAGIC;
            else if (dec_phase != PH_TOK)
               status = ST_TRUNC;
            else if (dec_total != dec_len)
               status = ST_MISMATCH;
         end
         r.stream_done = last;
         r.end_status  = status;
         r.bytes_out   = dec_total;
         predicted_runs.push_back(r);
      end

      // Return to the header phase after the final byte
      if (last) begin
         dec_phase = PH_HDR;
         dec_index = '0;
         dec_magic = '0;
         dec_len   = '0;
         dec_flags = '0;
         dec_run   = '0;
         dec_left  = '0;
         dec_word  = '0;
         dec_alpha = '0;
         dec_total = '0;
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stream building
   // ---------------------------------------------------------------------

   // Append one token, its extension bytes and its payload; track decoded size
   task automatic add_token(input token_kind_type kind, input logic [26:0] run,
                            input int ext_count);
      logic [7:0] lead;
      logic [7:0] grp;
      int         i;
      lead               = 8'h00;
      lead[FL_EXT_BIT]   = (ext_count > 0);
      lead[FL_REPE_BIT]  = (kind != TK_LITERAL);
      lead[FL_WORD_BIT]  = (kind == TK_RWORD || kind == TK_WORD_ALPHA);
      lead[FL_ALPH_BIT]  = (kind == TK_ALPHA || kind == TK_WORD_ALPHA);
      if (kind == TK_LITERAL)
         lead[5:0] = 6'(run >> (7 * ext_count));
      else
         lead[3:0] = 4'(run >> (7 * ext_count));
      stream_buf.push_back(lead);
      for (i = ext_count - 1; i >= 0; i--) begin
         grp = {1'b0, 7'(run >> (7 * i))};
         // The fourth length byte ends the length even with its flag set
         if (i > 0 || (ext_count == 3 && $urandom_range(1) == 1))
            grp[7] = 1'b1;
         stream_buf.push_back(grp);
      end
      case (kind)
         TK_LITERAL: begin
            for (i = 0; i < run; i++)
               stream_buf.push_back(8'($urandom));
            stream_total = stream_total + 32'(run);
         end
         TK_RBYTE: begin
            stream_buf.push_back(8'($urandom));
            stream_total = stream_total + 32'(run);
         end
         TK_RWORD, TK_WORD_ALPHA: begin
            repeat (4) stream_buf.push_back(8'($urandom));
            stream_total = stream_total + (32'(run) << 2);
         end
         default: begin
            stream_buf.push_back(8'($urandom));
            for (i = 0; i < 3 * run; i++)
               stream_buf.push_back(8'($urandom));
            stream_total = stream_total + (32'(run) << 2);
         end
      endcase
   endtask

   // Queue header and body; cut marks the final byte (0 keeps the whole stream)
   task automatic send_stream(input logic [31:0] magic, input logic [31:0] len,
                              input int cut);
      req_item_type item;
      int           full;
      int           stop;
      int           i;
      full = 8 + stream_buf.size();
      stop = (cut == 0 || cut > full) ? full : cut;
      for (i = 0; i < stop; i++) begin
         if (i < 4)
            item.in_byte = magic[8 * i +: 8];
         else if (i < 8)
            item.in_byte = len[8 * (i - 4) +: 8];
         else
            item.in_byte = stream_buf[i - 8];
         item.last_byte = (i == stop - 1);
         pending_bytes.push_back(item);
      end
      // Bytes skipped after a bad header do not count
      queued_count += (magic == MAGIC_WORD) ? stop : ((stop < 8) ? stop : 8);
   endtask

   task automatic queue_random_streams(input int target);
      token_kind_type kind;
      logic [26:0]    run;
      logic [31:0]    magic;
      logic [31:0]    len;
      int             ext;
      int             pick;
      int             cut;
      while (queued_count < target) begin
         stream_buf.delete();
         stream_total = '0;
         if ($urandom_range(99) < 12) begin
            // Noise: random header and a few random bytes
            repeat ($urandom_range(12)) stream_buf.push_back(8'($urandom));
            send_stream($urandom, $urandom, $urandom_range(20, 1));
         end else begin
            repeat ($urandom_range(5, 1)) begin
               kind = token_kind_type'($urandom_range(4));
               ext  = 0;
               case (kind)
                  TK_LITERAL: begin
                     run = ($urandom_range(9) == 0) ? 27'($urandom_range(63, 13))
                                                    : 27'($urandom_range(12));
                     ext = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
                  end
                  TK_ALPHA: begin
                     run = 27'($urandom_range(6));
                     ext = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
                  end
                  default: begin
                     pick = $urandom_range(99);
                     if (pick < 15) begin
                        run = '0;
                        ext = $urandom_range(1);
                     end else if (pick < 65) begin
                        run = 27'($urandom_range(15, 1));
                        ext = $urandom_range(1);
                     end else begin
                        ext = $urandom_range(3, 1);
                        run = 27'($urandom) & ((27'd1 << (4 + 7 * ext)) - 27'd1);
                     end
                  end
               endcase
               add_token(kind, run, ext);
            end
            magic = ($urandom_range(99) < 6) ? (MAGIC_WORD ^ (32'd1 << $urandom_range(31)))
                                             : MAGIC_WORD;
            len   = ($urandom_range(99) < 12) ? 32'($urandom) : stream_total;
            cut   = ($urandom_range(99) < 20) ? $urandom_range(8 + stream_buf.size(), 1) : 0;
            send_stream(magic, len, cut);
         end
      end
   endtask

   // Hold until every queued byte is taken and every result has arrived
   task automatic drain_all();
      while (pending_bytes.size() != 0 || req_bus.valid)
         @(negedge clock);
      while (predicted_runs.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Input driver: offer queued bytes, hold each until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : byte_source
      req_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item          = pending_bytes.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.in_byte   <= next_item.in_byte;
            req_bus.last_byte <= next_item.last_byte;
         end else begin
            req_bus.valid     <= 1'b0;
            req_bus.in_byte   <= 8'($urandom);
            req_bus.last_byte <= 1'($urandom);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result sink: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : result_sink
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (stall_requests != stall_served) begin
         stall_served  = stall_requests;
         stall_left    = STALL_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check results, predict from accepted bytes, watch the clock
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rle_stream_decoder_unit_tb: errors");
         $finish;
      end else begin
         req_taken = 1'b0;
         if (!reset) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               if (predicted_runs.size() == 0) begin
                  $error("result item with none expected: value %0h, done %0b",
                         rsp_bus.elem_value, rsp_bus.stream_done);
                  error_count++;
               end else begin
                  want = predicted_runs.pop_front();
                  check_field("elem_valid", want.elem_valid, rsp_bus.elem_valid);
                  check_field("elem_is_word", want.elem_is_word, rsp_bus.elem_is_word);
                  check_field("elem_value", want.elem_value, rsp_bus.elem_value);
                  check_field("repeat_count", want.repeat_count, rsp_bus.repeat_count);
                  check_field("stream_done", want.stream_done, rsp_bus.stream_done);
                  check_field("end_status", want.end_status, rsp_bus.end_status);
                  check_field("bytes_out", want.bytes_out, rsp_bus.bytes_out);
               end
            end
            if (req_bus.valid && req_bus.ready) begin
               req_taken = 1'b1;
               decode_byte(req_bus.in_byte, req_bus.last_byte);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.in_byte   = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      send_idle_pct     = 9;
      recv_idle_pct     = 65;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short stream: final byte inside the header
      stream_buf.delete();
      send_stream(MAGIC_WORD, 32'd0, 2);

      // Bad magic with all-ones header, then one skipped byte
      stream_buf.delete();
      stream_buf.push_back(8'h00);
      send_stream(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

      // Every mode, zero runs, word flag over alpha flag, maximum run
      stream_buf.delete();
      stream_total = '0;
      add_token(TK_LITERAL, 27'd0, 0);
      add_token(TK_LITERAL, 27'd3, 0);
      add_token(TK_RBYTE, 27'd0, 0);
      add_token(TK_RBYTE, 27'h1FF_FFFF, 3);
      add_token(TK_RWORD, 27'd1, 0);
      add_token(TK_RWORD, 27'd0, 1);
      add_token(TK_ALPHA, 27'd2, 0);
      add_token(TK_ALPHA, 27'd0, 0);
      add_token(TK_WORD_ALPHA, 27'd1, 0);
      add_token(TK_LITERAL, 27'd1, 2);
      send_stream(MAGIC_WORD, stream_total, 0);

      // Length mismatch
      stream_buf.delete();
      stream_total = '0;
      add_token(TK_RBYTE, 27'd5, 0);
      send_stream(MAGIC_WORD, stream_total + 32'd1, 0);

      // Truncated inside a literal payload
      stream_buf.delete();
      stream_total = '0;
      add_token(TK_LITERAL, 27'd4, 0);
      send_stream(MAGIC_WORD, stream_total, 11);

      // Slow receiver
      queued_count = 0;
      queue_random_streams(420);
      drain_all();

      // Slow sender
      send_idle_pct = 65;
      recv_idle_pct = 9;
      queue_random_streams(840);
      drain_all();

      // Full rate, opened by a long receiver hold-off and a wrapping total
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_requests++;
      stream_buf.delete();
      stream_total = '0;
      repeat (40)
         add_token(TK_RWORD, {2'b00, 4'(14 + $urandom_range(1)), 21'($urandom)}, 3);
      send_stream(MAGIC_WORD, stream_total, 0);
      queue_random_streams(1250);
      drain_all();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("rle_stream_decoder_unit_tb: clean");
      else
         $display("rle_stream_decoder_unit_tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
sv/rle_pkg.sv
sv/rle_req_if.sv
sv/rle_rsp_if.sv
sv/rle_req_stage.sv
sv/rle_parse_core.sv
sv/rle_rsp_buffer.sv
sv/rle_stream_decoder_unit.sv
sv/rle_stream_checker.sv
test/rle_stream_decoder_unit_tb.sv
